@@ src/srq_pkg.sv @@
// srq_pkg: constants, codes and shared types of the sequence reorder queue.
// No dependencies.
`default_nettype none
package srq_pkg;
	localparam int DEPTH = 32;
	localparam int SW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [23:0] TIMEOUT_RST = 24'd1000000;

	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_TICK = 2'd2,
		ACT_QUERY = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_DUP = 2'd1,
		ST_FULL = 2'd2,
		ST_MISS = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		E_IDLE,
		E_RCHK,
		E_WALK,
		E_FIX,
		E_HEAD,
		E_OUT
	} eng_state_t;

	typedef struct packed {
		action_t action;
		logic [31:0] seq;
		logic [15:0] tag;
		logic [15:0] len;
	} cmd_t;

	typedef struct packed {
		status_t status;
		logic head_valid;
		logic [31:0] head_seq;
		logic [15:0] head_tag;
		logic [15:0] head_len;
		logic [31:0] head_remaining;
		logic [5:0] occupancy;
	} res_t;
endpackage
`default_nettype wire

@@ src/srq_front.sv @@
// srq_front: input stage, two-entry command queue toward the list engine.
// Depends on srq_pkg.
`default_nettype none
module srq_front import srq_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire cmd_t in_cmd,
	output logic cmd_valid,
	input wire logic cmd_take,
	output cmd_t cmd
);
	cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign in_ready = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wp_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (cmd_take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(cmd_take);
		end
	end

	a_take_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid) else $error("take from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count overflow");
	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !cmd_take) |=> cnt_q == 2'd2) else $error("lost entry");
endmodule
`default_nettype wire

@@ src/srq_engine.sv @@
// srq_engine: linked-list store and walker that steps through the list node by node.
// Depends on srq_pkg.
`default_nettype none
module srq_engine import srq_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [23:0] timeout_ticks,
	input wire logic cmd_valid,
	output logic cmd_take,
	input wire cmd_t cmd,
	output logic res_valid,
	input wire logic res_ready,
	output res_t res
);
	logic [31:0] seq_mem [DEPTH];
	logic [15:0] tag_mem [DEPTH];
	logic [15:0] len_mem [DEPTH];
	logic [31:0] exp_mem [DEPTH];
	logic [SW-1:0] link_mem [DEPTH];
	logic [DEPTH-1:0] link_set_q;

	eng_state_t state_q, state_d;
	cmd_t cmd_q;
	logic [SW-1:0] head_q, tail_q, free_q, cur_q, prev_q;
	logic have_prev_q, found_q;
	logic [CW-1:0] count_q, idx_q;
	logic [31:0] now_q;
	status_t st_q;
	res_t res_q;
	logic res_valid_q;

	logic [SW-1:0] rd_addr;
	logic [31:0] rd_seq, rd_seq_q, rd_exp_q;
	logic [15:0] rd_tag_q, rd_len_q;
	logic [SW-1:0] rd_link_q;
	logic [SW-1:0] free_link_q;

	logic we;
	logic [SW-1:0] wa;
	logic [31:0] w_seq, w_exp;
	logic [15:0] w_tag, w_len;
	logic lwe;
	logic [SW-1:0] lwa, lwd;

	logic fix2_q;
	logic [SW-1:0] l2a_q, l2d_q;
	logic rem_step_q;
	logic [SW-1:0] old_free_q;
	logic [SW-1:0] link2_a, link2_d;
	logic link2_we;
	logic rem_q2;

	// node read: address chosen by the walker, data registered
	always_ff @(posedge clk) begin
		rd_seq_q <= seq_mem[rd_addr];
		rd_tag_q <= tag_mem[rd_addr];
		rd_len_q <= len_mem[rd_addr];
		rd_exp_q <= exp_mem[rd_addr];
	end
	assign rd_seq = rd_seq_q;

	// link reads: unset links read as the reset free chain (i+1) mod DEPTH
	always_ff @(posedge clk) begin
		rd_link_q <= link_set_q[rd_addr] ? link_mem[rd_addr]
			: SW'((32'(rd_addr) + 1) % DEPTH);
		free_link_q <= link_set_q[free_q] ? link_mem[free_q]
			: SW'((32'(free_q) + 1) % DEPTH);
	end

	// one link write port: FIX uses it first, HEAD and OUT afterwards
	always_ff @(posedge clk) begin
		if (we) begin
			seq_mem[wa] <= w_seq;
			tag_mem[wa] <= w_tag;
			len_mem[wa] <= w_len;
			exp_mem[wa] <= w_exp;
		end
		if (lwe) link_mem[lwa] <= lwd;
		else if (link2_we) link_mem[link2_a] <= link2_d;
	end

	logic is_add;
	logic walk_done, hit, less;
	assign is_add = (cmd_q.action == ACT_ADD);
	assign walk_done = (idx_q == count_q);
	assign hit = (rd_seq == cmd_q.seq);
	assign less = ($signed(cmd_q.seq) < $signed(rd_seq));

	always_comb begin
		state_d = state_q;
		cmd_take = 1'b0;
		rd_addr = cur_q;
		we = 1'b0;
		wa = free_q;
		w_seq = cmd_q.seq;
		w_tag = cmd_q.tag;
		w_len = cmd_q.len;
		w_exp = now_q + 32'(timeout_ticks);
		lwe = 1'b0;
		lwa = free_q;
		lwd = cur_q;
		case (state_q)
			E_IDLE: begin
				rd_addr = head_q;
				if (cmd_valid) begin
					cmd_take = 1'b1;
					state_d = E_RCHK;
				end
			end
			E_RCHK: state_d = E_WALK;
			E_WALK: begin
				if (cmd_q.action == ACT_TICK || cmd_q.action == ACT_QUERY)
					state_d = E_HEAD;
				else if (is_add && 32'(count_q) >= DEPTH)
					state_d = E_HEAD;
				else if (walk_done) state_d = E_FIX;
				else if (hit) state_d = E_FIX;
				else if (is_add && less) state_d = E_FIX;
				else begin
					rd_addr = rd_link_q;
					state_d = E_RCHK;
				end
			end
			E_FIX: begin
				rd_addr = head_q;
				state_d = E_HEAD;
				if (is_add && !found_q) begin
					we = 1'b1;
					if (!walk_done) begin
						lwe = 1'b1;
						lwa = free_q;
						lwd = cur_q;
					end
				end
			end
			E_HEAD: begin
				rd_addr = head_q;
				state_d = E_OUT;
			end
			E_OUT: begin
				// wait here until the result register is free to take this beat
				rd_addr = head_q;
				if (!res_valid_q) state_d = E_IDLE;
			end
			default: state_d = E_IDLE;
		endcase
	end

	// found_q marks a duplicate or a remove hit seen in the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			head_q <= '0;
			tail_q <= '0;
			free_q <= '0;
			count_q <= '0;
			now_q <= '0;
			link_set_q <= '0;
			idx_q <= '0;
			cur_q <= '0;
			prev_q <= '0;
			have_prev_q <= 1'b0;
			found_q <= 1'b0;
			st_q <= ST_OK;
		end else begin
			state_q <= state_d;
			if (lwe) link_set_q[lwa] <= 1'b1;
			else if (link2_we) link_set_q[link2_a] <= 1'b1;
			case (state_q)
				E_IDLE: if (cmd_valid) begin
					cur_q <= head_q;
					idx_q <= '0;
					have_prev_q <= 1'b0;
					found_q <= 1'b0;
					prev_q <= '0;
					st_q <= ST_OK;
				end
				E_WALK: begin
					if (cmd_q.action == ACT_TICK) now_q <= now_q + 32'd1;
					else if (cmd_q.action == ACT_QUERY) ;
					else if (is_add && 32'(count_q) >= DEPTH) st_q <= ST_FULL;
					else if (walk_done) begin
						if (!is_add) st_q <= ST_MISS;
					end else if (hit) begin
						found_q <= 1'b1;
						if (is_add) st_q <= ST_DUP;
					end else if (!(is_add && less)) begin
						prev_q <= cur_q;
						have_prev_q <= 1'b1;
						cur_q <= rd_link_q;
						idx_q <= idx_q + 1'b1;
					end
				end
				E_FIX: begin
					if (is_add && !found_q) begin
						free_q <= free_link_q;
						count_q <= count_q + 1'b1;
						if (walk_done) begin
							if (count_q == '0) head_q <= free_q;
							tail_q <= free_q;
						end else if (!have_prev_q) head_q <= free_q;
					end else if (!is_add && found_q) begin
						if (!have_prev_q) head_q <= rd_link_q;
						if (cur_q == tail_q) tail_q <= prev_q;
						free_q <= cur_q;
						count_q <= count_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// second link write (predecessor / tail / freed slot) in the cycle after FIX
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fix2_q <= 1'b0;
		else fix2_q <= (state_q == E_FIX) &&
			((is_add && !found_q && (have_prev_q || (walk_done && count_q != '0)))
			|| (!is_add && found_q));
	end
	always_ff @(posedge clk) begin
		rem_step_q <= (state_q == E_FIX) && !is_add && have_prev_q;
		if (state_q == E_FIX) begin
			if (is_add) begin
				l2a_q <= walk_done ? tail_q : prev_q;
				l2d_q <= free_q;
			end else begin
				l2a_q <= prev_q;
				l2d_q <= rd_link_q;
			end
		end
	end
	// remove: freed slot links to old free head; predecessor relinks in OUT
	always_ff @(posedge clk) if (state_q == E_FIX) old_free_q <= free_q;
	always_comb begin
		link2_we = 1'b0;
		link2_a = l2a_q;
		link2_d = l2d_q;
		if (state_q == E_HEAD && fix2_q) begin
			if (is_add) link2_we = 1'b1;
			else begin
				link2_we = 1'b1;
				link2_a = free_q;
				link2_d = old_free_q;
			end
		end else if (state_q == E_OUT && rem_q2) link2_we = 1'b1;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rem_q2 <= 1'b0;
		else rem_q2 <= (state_q == E_HEAD) && fix2_q && !is_add && rem_step_q;
	end

	always_ff @(posedge clk) if (cmd_take) cmd_q <= cmd;

	always_ff @(posedge clk) begin
		if (state_q == E_OUT && !res_valid_q) begin
			res_q.status <= st_q;
			res_q.head_valid <= (count_q != '0);
			res_q.head_seq <= (count_q != '0) ? rd_seq_q : '0;
			res_q.head_tag <= (count_q != '0) ? rd_tag_q : '0;
			res_q.head_len <= (count_q != '0) ? rd_len_q : '0;
			res_q.head_remaining <= (count_q != '0) ? rd_exp_q - now_q : '0;
			res_q.occupancy <= 6'(count_q);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (state_q == E_OUT && !res_valid_q) res_valid_q <= 1'b1;
		else if (res_valid_q && res_ready) res_valid_q <= 1'b0;
	end
	assign res_valid = res_valid_q;
	assign res = res_q;

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= DEPTH) else $error("count beyond depth");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> state_q == E_IDLE) else $error("take while busy");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == E_FIX) |=> $stable(now_q)) else $error("time moved in fix");
endmodule
`default_nettype wire

@@ src/sequence_reorder_queue.sv @@
// Sequence reorder queue: entries sorted by signed sequence number in a linked slot store.
// Add and remove walk the list node by node (registered store read in RCHK, then compare
// in WALK) over up to DEPTH nodes, then pass FIX, HEAD and OUT; tick, query and add to a
// full store go from WALK straight to HEAD and OUT.
// Throughput: one item in the engine; a two-beat queue in front and a one-beat result
// register behind let each side stall on its own. Reset (arst_n, async low): empty list,
// free chain in slot order, time zero, timeout 1000000; stores themselves are not cleared.
`default_nettype none
module sequence_reorder_queue import srq_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [23:0] cfg_wdata,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [63:0] s_axis_tdata, // seq, packet_tag, packet_len
	input wire logic [1:0] s_axis_tuser,  // action
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [103:0] m_axis_tdata, // head_valid, head_seq, head_tag, head_len,
	                                   // head_remaining, occupancy, zero pad
	output logic [1:0] m_axis_tuser    // status
);
	logic [23:0] timeout_q;
	cmd_t in_cmd, cmd;
	logic cmd_valid, cmd_take;
	res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) timeout_q <= TIMEOUT_RST;
		else if (cfg_we) timeout_q <= cfg_wdata;
	end

	always_comb begin
		in_cmd.action = action_t'(s_axis_tuser);
		in_cmd.seq = s_axis_tdata[31:0];
		in_cmd.tag = s_axis_tdata[47:32];
		in_cmd.len = s_axis_tdata[63:48];
	end

	srq_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
	);

	srq_engine u_engine (
		.clk(clk), .arst_n(arst_n), .timeout_ticks(timeout_q),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tuser = res.status;
	assign m_axis_tdata = {1'b0, res.occupancy, res.head_remaining, res.head_len,
		res.head_tag, res.head_seq, res.head_valid};
endmodule
`default_nettype wire
